[sv/sig_pkg.sv]
// ----------------------------------------------------------------------------
// sig_pkg
// shared widths, register indexes and types of the strided index generator
// ----------------------------------------------------------------------------
package sig_pkg;

  localparam int MAX_DIMS  = 4;
  localparam int SIZE_BITS = 16;

  localparam int NDIM      = 4;
  localparam int SIZE_W    = 16;
  localparam int STRIDE_W  = 32;
  localparam int LIN_W     = 64;
  localparam int OFF_W     = 50;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int PROD_W    = SIZE_BITS + STRIDE_W;
  localparam int HALF_DIMS = (MAX_DIMS + 1) / 2;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_DIM3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_DIM0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_DIM1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_DIM2 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_DIM3 = 3'd7;

  typedef logic [SIZE_BITS-1:0] cnt_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [OFF_W-1:0]     off_t;

  typedef struct packed {
    logic [LIN_W-1:0] lin;
    logic             last;
  } side_t;

endpackage

[sv/strided_index_generator_top.sv]
// ----------------------------------------------------------------------------
// strided_index_generator_top
// visit order of a strided copy: dense linear index and source offset
// ----------------------------------------------------------------------------
// Takes one request beat per clock while in_stall is low and returns one
// result beat per request, which moves through the pipeline: counter step,
// one 16x32 multiplier per dimension, a pair of partial sums, and the final
// add into the output register. Each stage holds its beat while the next
// one is full and cannot move on, so the pipeline keeps taking requests
// until all four stages are occupied. Sizes are read when a request is
// accepted and strides one stage later; the user must write the registers
// only while no beat is in flight; the block itself does not enforce this.
module strided_index_generator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sig_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sig_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sig_pkg::LIN_W-1:0]       out_linear_index,
  output logic [sig_pkg::OFF_W-1:0]       out_source_offset,
  output logic                            out_last
);

  // configuration
  logic [sig_pkg::SIZE_W-1:0]   size_r   [sig_pkg::NDIM];
  logic [sig_pkg::STRIDE_W-1:0] stride_r [sig_pkg::NDIM];

  // walk state
  sig_pkg::cnt_t              cnt_r [sig_pkg::MAX_DIMS];
  sig_pkg::cnt_t              cnt_nxt [sig_pkg::MAX_DIMS];
  logic [sig_pkg::LIN_W-1:0]  lin_r;
  logic [sig_pkg::LIN_W-1:0]  lin_nxt;

  // step logic
  sig_pkg::cnt_t              cur [sig_pkg::MAX_DIMS];
  logic [sig_pkg::MAX_DIMS-1:0] at_end;
  logic [sig_pkg::LIN_W-1:0]  lin_cur;
  logic                       last_c;

  // pipeline
  logic                       v1_r, v2_r, v3_r, vo_r;
  logic                       rdy1, rdy2, rdy3, rdyo;
  logic                       in_acc;
  sig_pkg::cnt_t              s1_cnt_r [sig_pkg::MAX_DIMS];
  sig_pkg::side_t             s1_side_r, s2_side_r, s3_side_r;
  sig_pkg::prod_t             s2_prod_r [sig_pkg::MAX_DIMS];
  sig_pkg::off_t              s3_a_r, s3_b_r;
  sig_pkg::off_t              sum_a, sum_b;
  logic [sig_pkg::LIN_W-1:0]  out_lin_r;
  sig_pkg::off_t              out_off_r;
  logic                       out_last_r;

  assign rdyo     = !vo_r || !out_stall;
  assign rdy3     = !v3_r || rdyo;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign in_acc   = in_valid && rdy1;

  // current element and wrap of the counters, innermost first
  always_comb begin
    logic                       carry;
    sig_pkg::cnt_t              eff;
    logic [sig_pkg::SIZE_BITS:0] inc;
    carry   = 1'b1;
    eff     = '0;
    inc     = '0;
    lin_cur = in_restart ? '0 : lin_r;
    for (int d = 0; d < sig_pkg::MAX_DIMS; d++) begin
      cur[d] = in_restart ? '0 : cnt_r[d];
      eff    = size_r[d][sig_pkg::SIZE_BITS-1:0];
      if (eff == '0) begin
        eff = sig_pkg::cnt_t'(1);
      end
      inc       = {1'b0, cur[d]} + (sig_pkg::SIZE_BITS+1)'(1);
      at_end[d] = inc >= {1'b0, eff};
    end
    last_c = &at_end;
    for (int d = sig_pkg::MAX_DIMS - 1; d >= 0; d--) begin
      if (carry) begin
        cnt_nxt[d] = at_end[d] ? '0 : cur[d] + sig_pkg::cnt_t'(1);
      end else begin
        cnt_nxt[d] = cur[d];
      end
      carry = carry && at_end[d];
    end
    lin_nxt = last_c ? '0 : lin_cur + sig_pkg::LIN_W'(1);
  end

  // two partial sums of the products
  always_comb begin
    sum_a = '0;
    sum_b = '0;
    for (int d = 0; d < sig_pkg::MAX_DIMS; d++) begin
      if (d < sig_pkg::HALF_DIMS) begin
        sum_a = sum_a + sig_pkg::OFF_W'(s2_prod_r[d]);
      end else begin
        sum_b = sum_b + sig_pkg::OFF_W'(s2_prod_r[d]);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < sig_pkg::NDIM; d++) begin
        size_r[d]   <= sig_pkg::SIZE_W'(1);
        stride_r[d] <= '0;
      end
      stride_r[sig_pkg::NDIM-1] <= sig_pkg::STRIDE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sig_pkg::REG_SIZE_DIM0:   size_r[0]   <= cfg_wdata[sig_pkg::SIZE_W-1:0];
        sig_pkg::REG_SIZE_DIM1:   size_r[1]   <= cfg_wdata[sig_pkg::SIZE_W-1:0];
        sig_pkg::REG_SIZE_DIM2:   size_r[2]   <= cfg_wdata[sig_pkg::SIZE_W-1:0];
        sig_pkg::REG_SIZE_DIM3:   size_r[3]   <= cfg_wdata[sig_pkg::SIZE_W-1:0];
        sig_pkg::REG_STRIDE_DIM0: stride_r[0] <= cfg_wdata;
        sig_pkg::REG_STRIDE_DIM1: stride_r[1] <= cfg_wdata;
        sig_pkg::REG_STRIDE_DIM2: stride_r[2] <= cfg_wdata;
        sig_pkg::REG_STRIDE_DIM3: stride_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < sig_pkg::MAX_DIMS; d++) begin
        cnt_r[d] <= '0;
      end
      lin_r <= '0;
    end else if (in_acc) begin
      for (int d = 0; d < sig_pkg::MAX_DIMS; d++) begin
        cnt_r[d] <= cnt_nxt[d];
      end
      lin_r <= lin_nxt;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdyo) vo_r <= v3_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int d = 0; d < sig_pkg::MAX_DIMS; d++) begin
        s1_cnt_r[d] <= cur[d];
      end
      s1_side_r.lin  <= lin_cur;
      s1_side_r.last <= last_c;
    end
    if (rdy2) begin
      for (int d = 0; d < sig_pkg::MAX_DIMS; d++) begin
        s2_prod_r[d] <= sig_pkg::PROD_W'(s1_cnt_r[d]) * sig_pkg::PROD_W'(stride_r[d]);
      end
      s2_side_r <= s1_side_r;
    end
    if (rdy3) begin
      s3_a_r    <= sum_a;
      s3_b_r    <= sum_b;
      s3_side_r <= s2_side_r;
    end
    if (rdyo) begin
      out_off_r  <= s3_a_r + s3_b_r;
      out_lin_r  <= s3_side_r.lin;
      out_last_r <= s3_side_r.last;
    end
  end

  assign out_valid         = vo_r;
  assign out_linear_index  = out_lin_r;
  assign out_source_offset = out_off_r;
  assign out_last          = out_last_r;

  // checks
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_restart |=> s1_side_r.lin == '0)
    else $error("restart beat without zero linear index");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && last_c |=> lin_r == '0 && cnt_r[sig_pkg::MAX_DIMS-1] == '0)
    else $error("walk did not wrap after final element");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(lin_r))
    else $error("linear index moved without a request beat");

endmodule

[tb/tb_strided_index_generator_top.sv]
// ----------------------------------------------------------------------------
// tb_strided_index_generator_top
// self-checking bench for the strided index generator
// ----------------------------------------------------------------------------
// A short table of directed requests and register writes runs first, then
// random phases: each phase reprograms some of the sizes and strides while
// the block is idle and then sends a burst of requests, some with restart.
// Every accepted request is run through a local model of the walk, and each
// result beat is compared field by field with the oldest expected entry. The
// sender idles in bursts, the receiver stalls on patterns of its own and
// holds off for long stretches so that the pipeline fills and back-pressures.
// ----------------------------------------------------------------------------
module tb_strided_index_generator_top;

  localparam int NUM_DIR     = 40;
  localparam int NUM_REQS    = 1500;
  localparam int QUIET_LIMIT = 1000;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    logic [sig_pkg::LIN_W-1:0] lin;
    logic [sig_pkg::OFF_W-1:0] off;
    logic                      last;
  } visit_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [sig_pkg::CFG_IDX_W-1:0] idx;
    logic [sig_pkg::CFG_W-1:0]     data;
    logic                          restart;
    logic                          fixed;
    visit_t                        v;
  } dir_row_t;

  typedef struct {
    logic   fixed;
    visit_t v;
  } req_tag_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [sig_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sig_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_restart = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [sig_pkg::LIN_W-1:0]     out_linear_index;
  logic [sig_pkg::OFF_W-1:0]     out_source_offset;
  logic                          out_last;

  // walk model: registers and counters
  logic [sig_pkg::SIZE_W-1:0]    geo_size [sig_pkg::NDIM] = '{default: 1};
  logic [sig_pkg::STRIDE_W-1:0]  geo_stride [sig_pkg::NDIM] = '{0, 0, 0, 1};
  logic [sig_pkg::SIZE_W-1:0]    walk_cnt [sig_pkg::NDIM] = '{default: 0};
  logic [sig_pkg::LIN_W-1:0]     walk_lin = '0;

  visit_t                pending_visits [$];
  req_tag_t              req_tags [$];
  dir_row_t              dir_rows [NUM_DIR];

  int                    mismatches = 0;
  int                    accepted_reqs = 0;
  int                    quiet_cycles = 0;
  int                    burst_left = 0;
  int                    sent_reqs = 0;

  strided_index_generator_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_linear_index  (out_linear_index),
    .out_source_offset (out_source_offset),
    .out_last          (out_last)
  );

  always #1 clk = ~clk;

  function automatic visit_t next_visit(input logic restart);
    visit_t                   v;
    logic [sig_pkg::SIZE_W:0] ext [sig_pkg::NDIM];
    logic [63:0]              acc;
    logic                     fin;
    logic                     carry;
    if (restart) begin
      for (int d = 0; d < sig_pkg::NDIM; d++) walk_cnt[d] = '0;
      walk_lin = '0;
    end
    fin = 1'b1;
    acc = '0;
    for (int d = 0; d < sig_pkg::NDIM; d++) begin
      ext[d] = (geo_size[d] == '0) ? (sig_pkg::SIZE_W+1)'(1) : {1'b0, geo_size[d]};
      if ({1'b0, walk_cnt[d]} + 1 < ext[d]) fin = 1'b0;
      acc += 64'(walk_cnt[d]) * 64'(geo_stride[d]);
    end
    v = '{walk_lin, acc[sig_pkg::OFF_W-1:0], fin};
    // innermost dimension steps first, carry outwards
    carry = 1'b1;
    for (int d = sig_pkg::NDIM - 1; d >= 0; d--) begin
      if (carry) begin
        if ({1'b0, walk_cnt[d]} + 1 < ext[d]) begin
          walk_cnt[d] = walk_cnt[d] + 1'b1;
          carry = 1'b0;
        end else begin
          walk_cnt[d] = '0;
        end
      end
    end
    walk_lin = fin ? '0 : walk_lin + 1'b1;
    return v;
  endfunction

  function automatic dir_row_t wr(input logic [sig_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [sig_pkg::CFG_W-1:0] data);
    return '{ROW_CFG, idx, data, 1'b0, 1'b0, '0};
  endfunction

  function automatic dir_row_t req(input logic restart);
    return '{ROW_ITEM, '0, '0, restart, 1'b0, '0};
  endfunction

  function automatic dir_row_t chk(input logic restart,
                                   input logic [sig_pkg::LIN_W-1:0] lin,
                                   input logic [sig_pkg::OFF_W-1:0] off,
                                   input logic last);
    return '{ROW_ITEM, '0, '0, restart, 1'b1, '{lin, off, last}};
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(input logic [sig_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sig_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // drop valid and wait until every request has come back
  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_visits.size() != 0 || req_tags.size() != 0) @(posedge clk);
  endtask

  task automatic send_req(input logic restart, input logic fixed, input visit_t v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 15) == 0) ? 300 : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid   <= 1'b0;
        in_restart <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_tags.push_back('{fixed, v});
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    sent_reqs++;
  endtask

  // model update and result check
  always @(posedge clk) begin
    req_tag_t tag;
    visit_t   want;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index <= sig_pkg::REG_SIZE_DIM3) begin
          geo_size[cfg_index[1:0]] = cfg_wdata[sig_pkg::SIZE_W-1:0];
        end else begin
          geo_stride[cfg_index[1:0]] = cfg_wdata[sig_pkg::STRIDE_W-1:0];
        end
      end
      if (in_valid && !in_stall) begin
        want = next_visit(in_restart);
        if (req_tags.size() == 0) begin
          report("request beat with no tag", 64'd0, 64'd1);
        end else begin
          tag = req_tags.pop_front();
          if (tag.fixed) want = tag.v;
        end
        pending_visits.push_back(want);
        accepted_reqs <= accepted_reqs + 1;
      end
      if (out_valid && !out_stall) begin
        if (pending_visits.size() == 0) begin
          report("result beat with nothing pending", 64'd1, 64'd0);
        end else begin
          want = pending_visits.pop_front();
          if (out_linear_index !== want.lin)
            report("linear_index", out_linear_index, want.lin);
          if (out_source_offset !== want.off)
            report("source_offset", 64'(out_source_offset), 64'(want.off));
          if (out_last !== want.last)
            report("last", 64'(out_last), 64'(want.last));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_strided_index_generator_top NOT OK");
        $finish;
      end
    end
  end

  // receiver stall patterns, with long hold-offs to fill the pipeline
  initial begin
    int mode;
    int len;
    int holdoffs;
    holdoffs = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if ((holdoffs == 0 && accepted_reqs >= 400) || (holdoffs == 1 && accepted_reqs >= 1000)) begin
        holdoffs++;
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(5, 60);
        repeat (len) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ~out_stall;
            default: out_stall <= ($urandom_range(0, 99) < 80);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    logic [sig_pkg::SIZE_W-1:0]   sz;
    logic [sig_pkg::STRIDE_W-1:0] st;
    int                           n;
    logic                         wrote;
    dir_rows = '{
      chk(1'b0, 64'd0, 50'd0, 1'b1),
      chk(1'b1, 64'd0, 50'd0, 1'b1),
      wr(sig_pkg::REG_SIZE_DIM3, 32'd3),
      wr(sig_pkg::REG_STRIDE_DIM3, 32'hFFFF_FFFF),
      chk(1'b0, 64'd0, 50'd0, 1'b0),
      chk(1'b0, 64'd1, 50'hFFFF_FFFF, 1'b0),
      chk(1'b0, 64'd2, 50'h1_FFFF_FFFE, 1'b1),
      chk(1'b0, 64'd0, 50'd0, 1'b0),
      chk(1'b1, 64'd0, 50'd0, 1'b0),
      chk(1'b0, 64'd1, 50'hFFFF_FFFF, 1'b0),
      // size of zero after masking, counter left above it
      wr(sig_pkg::REG_SIZE_DIM3, 32'hABCD_0000),
      chk(1'b0, 64'd2, 50'h1_FFFF_FFFE, 1'b1),
      chk(1'b0, 64'd0, 50'd0, 1'b1),
      wr(sig_pkg::REG_SIZE_DIM0, 32'hFFFF_FFFF),
      wr(sig_pkg::REG_SIZE_DIM1, 32'hFFFF_FFFF),
      wr(sig_pkg::REG_SIZE_DIM2, 32'hFFFF_FFFF),
      wr(sig_pkg::REG_SIZE_DIM3, 32'hFFFF_FFFF),
      wr(sig_pkg::REG_STRIDE_DIM0, 32'hFFFF_FFFF),
      wr(sig_pkg::REG_STRIDE_DIM1, 32'hFFFF_FFFF),
      wr(sig_pkg::REG_STRIDE_DIM2, 32'hFFFF_FFFF),
      wr(sig_pkg::REG_STRIDE_DIM3, 32'hFFFF_FFFF),
      chk(1'b1, 64'd0, 50'd0, 1'b0),
      chk(1'b0, 64'd1, 50'hFFFF_FFFF, 1'b0),
      // registers changed in the middle of a walk
      wr(sig_pkg::REG_STRIDE_DIM3, 32'd0),
      req(1'b0),
      wr(sig_pkg::REG_SIZE_DIM3, 32'd2),
      req(1'b0),
      req(1'b0),
      req(1'b0),
      wr(sig_pkg::REG_SIZE_DIM0, 32'd2),
      wr(sig_pkg::REG_SIZE_DIM1, 32'd1),
      wr(sig_pkg::REG_SIZE_DIM2, 32'd1),
      wr(sig_pkg::REG_SIZE_DIM3, 32'd2),
      wr(sig_pkg::REG_STRIDE_DIM0, 32'h8000_0000),
      wr(sig_pkg::REG_STRIDE_DIM3, 32'd3),
      req(1'b1),
      req(1'b0),
      req(1'b0),
      req(1'b0),
      req(1'b0)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIR; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (i == 0 || dir_rows[i-1].kind != ROW_CFG) settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
        if (i == NUM_DIR - 1 || dir_rows[i+1].kind != ROW_CFG) cfg_we <= 1'b0;
      end else begin
        send_req(dir_rows[i].restart, dir_rows[i].fixed, dir_rows[i].v);
      end
    end

    // random phases: reprogram while idle, then a burst of requests
    while (sent_reqs < NUM_REQS) begin
      settle();
      wrote = 1'b0;
      for (int d = 0; d < sig_pkg::NDIM; d++) begin
        if ($urandom_range(0, 9) < 7) begin
          case ($urandom_range(0, 9))
            0: sz = 16'd1;
            1: sz = 16'd0;
            2: sz = 16'hFFFF;
            3: sz = 16'($urandom);
            default: sz = 16'($urandom_range(1, 5));
          endcase
          write_reg(sig_pkg::CFG_IDX_W'(sig_pkg::REG_SIZE_DIM0 + d), {16'($urandom), sz});
          wrote = 1'b1;
        end
        if ($urandom_range(0, 9) < 7) begin
          case ($urandom_range(0, 9))
            0: st = '0;
            1: st = 32'hFFFF_FFFF;
            2, 3: st = $urandom;
            default: st = 32'($urandom_range(0, 64));
          endcase
          write_reg(sig_pkg::CFG_IDX_W'(sig_pkg::REG_STRIDE_DIM0 + d), st);
          wrote = 1'b1;
        end
      end
      if (wrote) cfg_we <= 1'b0;
      n = $urandom_range(10, 80);
      for (int k = 0; k < n; k++)
        send_req((k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 99) < 4),
                 1'b0, '0);
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_strided_index_generator_top OK");
    end else begin
      $display("tb_strided_index_generator_top NOT OK");
    end
    $finish;
  end

endmodule
